@@ sv/pbrle_pkg.sv @@
// ----------------------------------------------------------------------------
// PackBits RLE segment decoder package
// Shared widths, codes and the result descriptor type.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrle_pkg;

  localparam int unsigned PosBits  = 24;
  localparam int unsigned OposBits = PosBits + 1;
  localparam int unsigned SumBits  = OposBits + 1;
  localparam int unsigned CntBits  = 25;
  localparam int unsigned CfgBits  = 25;
  localparam int unsigned StrideBits = 8;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned ProdBits = 2 * ByteBits;
  localparam int unsigned CmpBits  = (SumBits > CntBits + 1) ? SumBits : CntBits + 1;

  localparam logic [CntBits-1:0]  CntMax  = '1;
  localparam logic [ByteBits-1:0] CtrlNop = 8'h80;

  typedef enum logic [1:0] {
    CFG_SEGMENT_LENGTH = 2'd0,
    CFG_OUT_LENGTH     = 2'd1,
    CFG_START_POSITION = 2'd2,
    CFG_STRIDE         = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_HALTED  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SEG_END = 2'd1,
    ST_OUT_END = 2'd2,
    ST_HALTED  = 2'd3
  } status_e;

  typedef struct packed {
    logic                write_valid;
    logic [ByteBits-1:0] value;
    logic [PosBits-1:0]  first_position;
    logic [ByteBits-1:0] burst_count;
    status_e             status;
    logic                finished;
  } result_t;

endpackage

`default_nettype wire

@@ sv/pbrle_result_buf.sv @@
// ----------------------------------------------------------------------------
// PackBits RLE result buffer
// Two-entry result queue that decouples the decode stage from the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrle_result_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pbrle_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_i,
  output pbrle_pkg::result_t pop_data_o
);

  pbrle_pkg::result_t head_q, head_d;
  pbrle_pkg::result_t tail_q, tail_d;
  logic               head_vld_q, head_vld_d;
  logic               tail_vld_q, tail_vld_d;
  logic               pop;

  assign ready_o    = !tail_vld_q;
  assign valid_o    = head_vld_q;
  assign pop_data_o = head_q;
  assign pop        = head_vld_q && pop_i;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    if (pop) begin
      if (tail_vld_q) begin
        head_d     = tail_q;
        tail_vld_d = 1'b0;
      end else begin
        head_d     = push_data_i;
        head_vld_d = push_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_d     = push_data_i;
        head_vld_d = 1'b1;
      end else begin
        tail_d     = push_data_i;
        tail_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

`default_nettype wire

@@ sv/packbits_rle_segment_decoder.sv @@
// ----------------------------------------------------------------------------
// PackBits RLE segment decoder
// Decodes one encoded byte per transfer into one strided write burst result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_ready_o | data_byte_i
//  out     | out       | out_valid_o/out_ready_i | write_valid_o .. finished_o
//
//  One byte per cycle while the result queue has room; each result is registered.
//  The decode state updates on each transfer from the byte and the state,
//  one shared 8x8 multiply sets the path to the result register.
//  A two-entry result queue keeps the input open while one result waits.
//  Reset loads register defaults and the control phase; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_rle_segment_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_addr_i,
  input  logic [pbrle_pkg::CfgBits-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pbrle_pkg::ByteBits-1:0]    data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              write_valid_o,
  output logic [pbrle_pkg::ByteBits-1:0]    value_o,
  output logic [pbrle_pkg::PosBits-1:0]     first_position_o,
  output logic [pbrle_pkg::ByteBits-1:0]    burst_count_o,
  output logic [1:0]                        status_o,
  output logic                              finished_o
);

  logic [pbrle_pkg::CntBits-1:0]    seg_len_q;
  logic [pbrle_pkg::CntBits-1:0]    out_len_q;
  logic [pbrle_pkg::PosBits-1:0]    start_pos_q;
  logic [pbrle_pkg::StrideBits-1:0] stride_q;

  pbrle_pkg::phase_e                phase_q, phase_d;
  logic [pbrle_pkg::ByteBits-1:0]   lit_rem_q, lit_rem_d;
  logic [pbrle_pkg::ByteBits-1:0]   rep_cnt_q, rep_cnt_d;
  logic [pbrle_pkg::OposBits-1:0]   opos_q, opos_d;
  logic [pbrle_pkg::CntBits-1:0]    bc_q, bc_d;

  logic                             push;
  pbrle_pkg::result_t               res_d;
  pbrle_pkg::result_t               res_out;

  logic [pbrle_pkg::OposBits-1:0]   opos;
  logic                             beyond;
  logic [pbrle_pkg::CntBits-1:0]    bc_inc;
  logic [pbrle_pkg::CntBits-1:0]    seg_rem;
  logic                             run_end;
  pbrle_pkg::phase_e                end_phase;
  logic [pbrle_pkg::ByteBits-2:0]   b_nm1;
  logic [pbrle_pkg::ByteBits-1:0]   n_lit;
  logic [pbrle_pkg::ByteBits-1:0]   n_rep;
  logic [pbrle_pkg::ByteBits-1:0]   mul_a;
  logic [pbrle_pkg::ProdBits-1:0]   prod;
  logic [pbrle_pkg::SumBits-1:0]    pos_sum;
  logic                             out_over;
  logic                             opos_full;
  logic                             lit_short;
  logic [pbrle_pkg::ByteBits-1:0]   lit_dec;
  logic                             is_ctrl_lit;
  logic                             is_ctrl_nop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q   <= '0;
      out_len_q   <= '0;
      start_pos_q <= '0;
      stride_q    <= pbrle_pkg::StrideBits'(1);
    end else if (cfg_we_i) begin
      unique case (pbrle_pkg::cfg_reg_e'(cfg_addr_i))
        pbrle_pkg::CFG_SEGMENT_LENGTH: seg_len_q   <= cfg_wdata_i[pbrle_pkg::CntBits-1:0];
        pbrle_pkg::CFG_OUT_LENGTH:     out_len_q   <= cfg_wdata_i[pbrle_pkg::CntBits-1:0];
        pbrle_pkg::CFG_START_POSITION: start_pos_q <= cfg_wdata_i[pbrle_pkg::PosBits-1:0];
        pbrle_pkg::CFG_STRIDE:         stride_q    <= cfg_wdata_i[pbrle_pkg::StrideBits-1:0];
        default: ;
      endcase
    end
  end

  assign push = in_valid_i && in_ready_o;

  // shared decode terms
  assign opos    = (bc_q == '0) ? {1'b0, start_pos_q} : opos_q;
  assign beyond  = bc_q >= seg_len_q;
  assign bc_inc  = (bc_q == pbrle_pkg::CntMax) ? bc_q : bc_q + pbrle_pkg::CntBits'(1);
  assign seg_rem = seg_len_q - bc_inc;
  assign run_end = ({1'b0, bc_inc} + (pbrle_pkg::CntBits + 1)'(1)) >= {1'b0, seg_len_q};
  assign end_phase = run_end ? pbrle_pkg::PH_HALTED : pbrle_pkg::PH_CONTROL;

  assign is_ctrl_lit = !data_byte_i[pbrle_pkg::ByteBits-1];
  assign is_ctrl_nop = data_byte_i == pbrle_pkg::CtrlNop;
  assign b_nm1 = is_ctrl_lit ? data_byte_i[pbrle_pkg::ByteBits-2:0]
                             : (pbrle_pkg::ByteBits-1)'(0) - data_byte_i[pbrle_pkg::ByteBits-2:0];
  assign n_lit = {1'b0, data_byte_i[pbrle_pkg::ByteBits-2:0]} + pbrle_pkg::ByteBits'(1);
  assign n_rep = {1'b0, b_nm1} + pbrle_pkg::ByteBits'(1);

  always_comb begin
    unique case (phase_q)
      pbrle_pkg::PH_REPEAT:  mul_a = rep_cnt_q;
      pbrle_pkg::PH_LITERAL: mul_a = pbrle_pkg::ByteBits'(1);
      default:               mul_a = {1'b0, b_nm1};
    endcase
  end

  assign prod      = mul_a * stride_q;
  assign pos_sum   = {1'b0, opos} + pbrle_pkg::SumBits'(prod);
  assign out_over  = pbrle_pkg::CmpBits'(pos_sum) >= pbrle_pkg::CmpBits'(out_len_q);
  assign opos_full = pbrle_pkg::CmpBits'(opos) >= pbrle_pkg::CmpBits'(out_len_q);
  assign lit_short = seg_rem < pbrle_pkg::CntBits'(n_lit);
  assign lit_dec   = (lit_rem_q != '0) ? lit_rem_q - pbrle_pkg::ByteBits'(1) : lit_rem_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    lit_rem_d = lit_rem_q;
    rep_cnt_d = rep_cnt_q;
    opos_d    = opos;
    bc_d      = bc_inc;
    unique case (phase_q)
      pbrle_pkg::PH_CONTROL: begin
        if (beyond || opos_full) begin
          phase_d = pbrle_pkg::PH_HALTED;
        end else if (is_ctrl_lit) begin
          if (lit_short || out_over) begin
            phase_d = pbrle_pkg::PH_HALTED;
          end else begin
            lit_rem_d = n_lit;
            phase_d   = pbrle_pkg::PH_LITERAL;
          end
        end else if (is_ctrl_nop) begin
          phase_d = end_phase;
        end else begin
          if (out_over || seg_rem == '0) begin
            phase_d = pbrle_pkg::PH_HALTED;
          end else begin
            rep_cnt_d = n_rep;
            phase_d   = pbrle_pkg::PH_REPEAT;
          end
        end
      end
      pbrle_pkg::PH_LITERAL: begin
        if (beyond) begin
          phase_d = pbrle_pkg::PH_HALTED;
        end else begin
          opos_d    = pos_sum[pbrle_pkg::OposBits-1:0];
          lit_rem_d = lit_dec;
          if (lit_dec == '0) begin
            phase_d = end_phase;
          end
        end
      end
      pbrle_pkg::PH_REPEAT: begin
        if (beyond) begin
          phase_d = pbrle_pkg::PH_HALTED;
        end else begin
          opos_d    = pos_sum[pbrle_pkg::OposBits-1:0];
          rep_cnt_d = '0;
          phase_d   = end_phase;
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res_d                = '0;
    res_d.status         = pbrle_pkg::ST_OK;
    res_d.finished       = !beyond && (bc_inc == seg_len_q);
    unique case (phase_q)
      pbrle_pkg::PH_CONTROL: begin
        if (beyond || opos_full) begin
          res_d.status = pbrle_pkg::ST_HALTED;
        end else if (is_ctrl_lit) begin
          if (lit_short) begin
            res_d.status = pbrle_pkg::ST_SEG_END;
          end else if (out_over) begin
            res_d.status = pbrle_pkg::ST_OUT_END;
          end
        end else if (!is_ctrl_nop) begin
          if (out_over) begin
            res_d.status = pbrle_pkg::ST_OUT_END;
          end else if (seg_rem == '0) begin
            res_d.status = pbrle_pkg::ST_SEG_END;
          end
        end
      end
      pbrle_pkg::PH_LITERAL, pbrle_pkg::PH_REPEAT: begin
        if (beyond) begin
          res_d.status = pbrle_pkg::ST_HALTED;
        end else begin
          res_d.write_valid    = 1'b1;
          res_d.value          = data_byte_i;
          res_d.first_position = opos[pbrle_pkg::PosBits-1:0];
          res_d.burst_count    = (phase_q == pbrle_pkg::PH_REPEAT) ? rep_cnt_q
                                                                  : pbrle_pkg::ByteBits'(1);
        end
      end
      default: begin
        res_d.status = pbrle_pkg::ST_HALTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pbrle_pkg::PH_CONTROL;
      lit_rem_q <= '0;
      rep_cnt_q <= '0;
      opos_q    <= '0;
      bc_q      <= '0;
    end else if (push) begin
      phase_q   <= phase_d;
      lit_rem_q <= lit_rem_d;
      rep_cnt_q <= rep_cnt_d;
      opos_q    <= opos_d;
      bc_q      <= bc_d;
    end
  end

  pbrle_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res_d),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_i       (out_ready_i),
    .pop_data_o  (res_out)
  );

  assign write_valid_o    = res_out.write_valid;
  assign value_o          = res_out.value;
  assign first_position_o = res_out.first_position;
  assign burst_count_o    = res_out.burst_count;
  assign status_o         = res_out.status;
  assign finished_o       = res_out.finished;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pbrle_pkg::PH_HALTED |=> phase_q == pbrle_pkg::PH_HALTED)
    else $error("decoder left halted phase");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res_d.write_valid |-> res_d.status == pbrle_pkg::ST_OK)
    else $error("write burst carries error status");

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_count_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && bc_q != pbrle_pkg::CntMax |=> bc_q == $past(bc_q) + pbrle_pkg::CntBits'(1))
    else $error("byte count did not advance on transfer");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// PackBits RLE segment decoder testbench
// Streams encoded bytes through the decoder under varied flow control.
// A software copy of the decode state predicts the result for every
// byte, and each result is compared field by field in order.
// Stride and start position change between phases, and the decoder is
// drained mid-phase and at phase end. The run ends on one halting condition
// picked at random: a literal past the segment end, a repeat with no data
// byte, a run past the output end, a full output, or an exhausted segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import pbrle_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseItems  = 285;
  localparam int unsigned TailItems   = 40;
  localparam longint unsigned RunMargin = 40000;
  localparam logic [CfgBits-1:0] FullSpan = 25'h100_0000;
  localparam logic [ByteBits-1:0] OpeningBytes [15] = '{
    8'h00, 8'hFF, CtrlNop, 8'h81, 8'hA5, 8'hFF, 8'h00, 8'h02,
    8'h01, 8'h80, 8'h7F, 8'hFE, 8'h80, 8'hC0, 8'hFF
  };

  class rle_burst_tracker;
    logic [CfgBits-1:0]    seg_len;
    logic [CfgBits-1:0]    out_len;
    logic [PosBits-1:0]    start_pos;
    logic [StrideBits-1:0] stride;
    phase_e                ph;
    logic [ByteBits-1:0]   lit_left;
    logic [ByteBits-1:0]   rep_cnt;
    logic [OposBits-1:0]   pos;
    logic [CntBits-1:0]    consumed;
    result_t               expected_bursts[$];
    int unsigned           mismatches;

    function new();
      seg_len   = '0;
      out_len   = '0;
      start_pos = '0;
      stride    = 8'd1;
      ph        = PH_CONTROL;
      lit_left  = '0;
      rep_cnt   = '0;
      pos       = '0;
      consumed  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgBits-1:0] v);
      case (idx)
        CFG_SEGMENT_LENGTH: seg_len = v;
        CFG_OUT_LENGTH:     out_len = v;
        CFG_START_POSITION: start_pos = v[PosBits-1:0];
        CFG_STRIDE:         stride = v[StrideBits-1:0];
        default: ;
      endcase
    endfunction

    function void close_run();
      ph = (64'(consumed) + 1 >= 64'(seg_len)) ? PH_HALTED : PH_CONTROL;
    endfunction

    function void accept_byte(logic [ByteBits-1:0] b);
      result_t r;
      logic beyond;
      longint unsigned n;
      r = '0;
      if (consumed == '0) pos = OposBits'(start_pos);
      beyond = (consumed >= seg_len);
      if (consumed != CntMax) consumed = consumed + 1'b1;
      case (ph)
        PH_CONTROL: begin
          if (beyond || pos >= out_len) begin
            r.status = ST_HALTED;
            ph = PH_HALTED;
          end else if (b < CtrlNop) begin
            n = 64'(b) + 1;
            if (64'(seg_len) - 64'(consumed) < n) begin
              r.status = ST_SEG_END;
              ph = PH_HALTED;
            end else if (64'(pos) + (n - 1) * 64'(stride) >= 64'(out_len)) begin
              r.status = ST_OUT_END;
              ph = PH_HALTED;
            end else begin
              lit_left = ByteBits'(n);
              ph = PH_LITERAL;
            end
          end else if (b == CtrlNop) begin
            close_run();
          end else begin
            n = 257 - 64'(b);
            if (64'(pos) + (n - 1) * 64'(stride) >= 64'(out_len)) begin
              r.status = ST_OUT_END;
              ph = PH_HALTED;
            end else if (consumed >= seg_len) begin
              r.status = ST_SEG_END;
              ph = PH_HALTED;
            end else begin
              rep_cnt = ByteBits'(n);
              ph = PH_REPEAT;
            end
          end
        end
        PH_LITERAL, PH_REPEAT: begin
          if (beyond) begin
            r.status = ST_HALTED;
            ph = PH_HALTED;
          end else begin
            r.write_valid    = 1'b1;
            r.value          = b;
            r.first_position = pos[PosBits-1:0];
            if (ph == PH_LITERAL) begin
              r.burst_count = 8'd1;
              pos = pos + OposBits'(stride);
              if (lit_left != '0) lit_left = lit_left - 1'b1;
              if (lit_left == '0) close_run();
            end else begin
              r.burst_count = rep_cnt;
              pos = OposBits'(64'(pos) + 64'(rep_cnt) * 64'(stride));
              rep_cnt = '0;
              close_run();
            end
          end
        end
        default: r.status = ST_HALTED;
      endcase
      r.finished = !beyond && (consumed == seg_len);
      expected_bursts.push_back(r);
    endfunction

    function void compare_burst(logic wv, logic [ByteBits-1:0] val,
                                logic [PosBits-1:0] fpos, logic [ByteBits-1:0] cnt,
                                logic [1:0] st, logic fin);
      result_t e;
      if (expected_bursts.size() == 0) begin
        $error("burst with no byte outstanding: value %0h position %0d", val, fpos);
        mismatches++;
        return;
      end
      e = expected_bursts.pop_front();
      if (wv !== e.write_valid) begin
        $error("write_valid: expected %0d, actual %0d", e.write_valid, wv);
        mismatches++;
      end
      if (val !== e.value) begin
        $error("value: expected %0h, actual %0h", e.value, val);
        mismatches++;
      end
      if (fpos !== e.first_position) begin
        $error("first_position: expected %0d, actual %0d", e.first_position, fpos);
        mismatches++;
      end
      if (cnt !== e.burst_count) begin
        $error("burst_count: expected %0d, actual %0d", e.burst_count, cnt);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        mismatches++;
      end
      if (fin !== e.finished) begin
        $error("finished: expected %0d, actual %0d", e.finished, fin);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [1:0]          cfg_addr_i  = '0;
  logic [CfgBits-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [ByteBits-1:0] data_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                write_valid_o;
  logic [ByteBits-1:0] value_o;
  logic [PosBits-1:0]  first_position_o;
  logic [ByteBits-1:0] burst_count_o;
  logic [1:0]          status_o;
  logic                finished_o;

  int unsigned         in_idle_pct   = 0;
  int unsigned         out_stall_pct = 0;
  int unsigned         idle_cycles   = 0;
  rle_burst_tracker    tracker;
  logic [ByteBits-1:0] byte_plan[$];

  packbits_rle_segment_decoder dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.compare_burst(write_valid_o, value_o, first_position_o, burst_count_o,
                              status_o, finished_o);
      end
      out_ready_i <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgBits-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    tracker.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic send_byte(logic [ByteBits-1:0] b);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < in_idle_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.accept_byte(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_bursts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // keep runs clear of the output end so decoding never halts by accident
  function automatic void plan_run();
    longint unsigned span;
    longint unsigned cap;
    longint unsigned n;
    int unsigned pick;
    span = (tracker.out_len > tracker.pos) ? 64'(tracker.out_len) - 64'(tracker.pos) : 0;
    cap = (span > RunMargin) ?
          (span - RunMargin) / ((tracker.stride == '0) ? 1 : 64'(tracker.stride)) : 0;
    if (cap > 128) cap = 128;
    pick = $urandom_range(0, 99);
    if (pick < 8 && cap == 128) begin
      byte_plan.push_back(ByteBits'($urandom_range(0, 255)));
    end else if (pick < 14 || cap < 2) begin
      byte_plan.push_back(CtrlNop);
    end else if (pick < 55) begin
      n = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 16) : $urandom_range(1, 128);
      if (n > cap) n = cap;
      byte_plan.push_back(ByteBits'(n - 1));
      repeat (n) byte_plan.push_back(ByteBits'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 9))
        0: n = 2;
        1: n = 128;
        default: n = $urandom_range(2, 128);
      endcase
      if (n > cap) n = cap;
      byte_plan.push_back(ByteBits'(257 - n));
      byte_plan.push_back(ByteBits'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CFG_SEGMENT_LENGTH, FullSpan);
    write_reg(CFG_OUT_LENGTH, FullSpan);
    write_reg(CFG_START_POSITION, CfgBits'($urandom_range(0, 4095)));
    write_reg(CFG_STRIDE, 25'd1);
    cfg_we_i <= 1'b0;
    foreach (OpeningBytes[k]) send_byte(OpeningBytes[k]);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 82; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 82; end
        default: begin in_idle_pct = 6; out_stall_pct = 6; end
      endcase
      case (p)
        0: write_reg(CFG_STRIDE, 25'd255);
        1: write_reg(CFG_STRIDE, CfgBits'($urandom_range(1, 8)));
        2: write_reg(CFG_STRIDE, 25'd0);
        3: begin
          write_reg(CFG_STRIDE, CfgBits'($urandom_range(1, 255)));
          write_reg(CFG_START_POSITION, 25'hFF_FFFF);
        end
        default: write_reg(CFG_STRIDE, CfgBits'($urandom_range(1, 4)));
      endcase
      cfg_we_i <= 1'b0;
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) drain();
        if (byte_plan.size() == 0) plan_run();
        send_byte(byte_plan.pop_front());
      end
      drain();
    end

    // finish the open run, then halt the segment one way
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
    drain();
    in_idle_pct   = $urandom_range(0, 1) ? 0 : 82;
    out_stall_pct = $urandom_range(0, 1) ? 0 : 82;
    write_reg(CFG_OUT_LENGTH, FullSpan);
    write_reg(CFG_STRIDE, CfgBits'($urandom_range(1, 255)));
    case ($urandom_range(0, 4))
      0: begin
        write_reg(CFG_SEGMENT_LENGTH,
                  CfgBits'(tracker.consumed) + CfgBits'($urandom_range(1, 4)));
        byte_plan.push_back(ByteBits'($urandom_range(4, 127)));
      end
      1: begin
        write_reg(CFG_SEGMENT_LENGTH, CfgBits'(tracker.consumed) + 1'b1);
        byte_plan.push_back(ByteBits'($urandom_range(129, 255)));
      end
      2: begin
        write_reg(CFG_STRIDE, CfgBits'($urandom_range(2, 255)));
        write_reg(CFG_OUT_LENGTH, CfgBits'(tracker.pos) + CfgBits'($urandom_range(1, 200)));
        byte_plan.push_back($urandom_range(0, 1) ? 8'h7F : 8'h81);
      end
      3: write_reg(CFG_OUT_LENGTH, $urandom_range(0, 1) ? '0 : CfgBits'(tracker.pos));
      default: begin
        write_reg(CFG_SEGMENT_LENGTH, ($urandom_range(0, 3) == 0) ? '0 :
                  CfgBits'(tracker.consumed) + CfgBits'($urandom_range(1, 30)));
      end
    endcase
    cfg_we_i <= 1'b0;
    for (int i = 0; i < TailItems; i++) begin
      if (byte_plan.size() == 0) plan_run();
      send_byte(byte_plan.pop_front());
    end
    drain();

    if (tracker.mismatches == 0 && tracker.expected_bursts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/pbrle_pkg.sv
sv/pbrle_result_buf.sv
sv/packbits_rle_segment_decoder.sv
dv/tb.sv
